@@ design/wsts_pkg.sv @@
// Shared types and constants for the weighted sum tree select core.
package wsts_pkg;

  localparam int DEF_MAX_LEAVES = 1024;
  localparam int QUEUE_DEPTH    = 2;
  localparam int ID_W           = 16;
  localparam int WEIGHT_W       = 32;
  localparam int QUERY_W        = 40;

  // request kind, decided by the front
  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_t;

  // one queued request
  typedef struct packed {
    kind_t                kind;
    logic [ID_W-1:0]      leaf_id;
    logic [WEIGHT_W-1:0]  leaf_weight;
    logic                 last_leaf;
    logic [QUERY_W-1:0]   query_value;
  } req_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // back end status
  typedef struct packed {
    logic idle;
    logic pop;
  } bk_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_STEP,
    BK_CMP,
    BK_FETCH,
    BK_DONE
  } bk_state_t;

endpackage

@@ design/wsts_queue.sv @@
// Small request queue between front and back.
module wsts_queue
  import wsts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  req_t    push_req,
  input  logic    pop,
  output req_t    pop_req,
  output q_stat_t stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

  assign pop_req    = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

@@ design/wsts_front.sv @@
// Front end: takes requests, classifies them and pushes them to the queue.
module wsts_front
  import wsts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [ID_W-1:0]     in_leaf_id,
  input  logic [WEIGHT_W-1:0] in_leaf_weight,
  input  logic                in_last_leaf,
  input  logic [QUERY_W-1:0]  in_query_value,
  input  q_stat_t             q_stat,
  output logic                push,
  output req_t                push_req
);

  logic valid_r, valid_nxt;
  req_t req_r;
  logic accept;

  assign busy   = valid_r && q_stat.full;
  assign accept = start && !busy;
  assign push   = valid_r && !q_stat.full;

  always_comb begin
    valid_nxt = accept || (valid_r && q_stat.full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // classify and hold the request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.kind        <= in_func ? KIND_SEARCH : KIND_LOAD;
      req_r.leaf_id     <= in_leaf_id;
      req_r.leaf_weight <= in_leaf_weight;
      req_r.last_leaf   <= in_last_leaf;
      req_r.query_value <= in_query_value;
    end
  end

  assign push_req = req_r;

endmodule

@@ design/wsts_back.sv @@
// Back end: leaf table with prefix sums, loads and binary-search descent.
module wsts_back
  import wsts_pkg::*;
#(
  parameter int MAX_LEAVES = DEF_MAX_LEAVES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  q_stat_t             q_stat,
  input  req_t                req,
  output bk_stat_t            stat,
  output logic                out_strobe,
  output logic [ID_W-1:0]     out_found_id,
  output logic [WEIGHT_W-1:0] out_found_weight,
  output logic                out_status
);

  localparam int AW     = $clog2(MAX_LEAVES);
  localparam int CNT_W  = $clog2(MAX_LEAVES + 1);
  localparam int PSUM_W = WEIGHT_W + AW;
  localparam int CMP_W  = (PSUM_W > QUERY_W) ? PSUM_W : QUERY_W;

  // leaf table: id, weight and inclusive prefix sum per leaf
  logic [ID_W-1:0]     mem_id   [MAX_LEAVES];
  logic [WEIGHT_W-1:0] mem_w    [MAX_LEAVES];
  logic [PSUM_W-1:0]   mem_p    [MAX_LEAVES];
  logic [ID_W-1:0]     rd_id_r;
  logic [WEIGHT_W-1:0] rd_w_r;
  logic [PSUM_W-1:0]   rd_p_r;

  bk_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [PSUM_W-1:0]   run_r, run_nxt;
  logic                ready_r, ready_nxt;
  logic [AW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [QUERY_W-1:0]  x_r, x_nxt;
  logic                ostb_r, ostb_nxt;
  logic [ID_W-1:0]     oid_r, oid_nxt;
  logic [WEIGHT_W-1:0] ow_r, ow_nxt;
  logic                ost_r, ost_nxt;

  logic                wr_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [PSUM_W-1:0]   wr_psum;
  logic [CNT_W-1:0]    eff_count;
  logic [PSUM_W-1:0]   eff_run;
  logic [AW:0]         mid_sum;
  logic                go_left;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign go_left = CMP_W'(x_r) <= CMP_W'(rd_p_r);

  // control
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    run_nxt   = run_r;
    ready_nxt = ready_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    x_nxt     = x_r;
    ostb_nxt  = 1'b0;
    oid_nxt   = oid_r;
    ow_nxt    = ow_r;
    ost_nxt   = ost_r;
    wr_en     = 1'b0;
    stat.pop  = 1'b0;
    stat.idle = (state_r == BK_IDLE);
    eff_count = ready_r ? '0 : count_r;
    eff_run   = ready_r ? '0 : run_r;
    wr_addr   = eff_count[AW-1:0];
    wr_psum   = eff_run + PSUM_W'(req.leaf_weight);
    rd_addr   = lo_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          stat.pop = 1'b1;
          if (req.kind == KIND_LOAD) begin
            // a load after a finished set starts a new one
            count_nxt = eff_count;
            run_nxt   = eff_run;
            ready_nxt = 1'b0;
            if (eff_count < CNT_W'(MAX_LEAVES)) begin
              wr_en     = 1'b1;
              count_nxt = eff_count + 1'b1;
              run_nxt   = wr_psum;
            end
            if (req.last_leaf) begin
              ready_nxt = 1'b1;
            end
          end else if (!ready_r || count_r == '0) begin
            ostb_nxt = 1'b1;
            oid_nxt  = '0;
            ow_nxt   = '0;
            ost_nxt  = 1'b1;
          end else begin
            x_nxt  = req.query_value;
            lo_nxt = '0;
            hi_nxt = AW'(count_r - 1'b1);
            if (count_r == CNT_W'(1)) begin
              state_nxt = BK_FETCH;
            end else begin
              state_nxt = BK_STEP;
            end
          end
        end
      end
      BK_STEP: begin
        // read the prefix sum at the midpoint
        mid_nxt   = mid_sum[AW:1];
        rd_addr   = mid_sum[AW:1];
        state_nxt = BK_CMP;
      end
      BK_CMP: begin
        // first leaf whose prefix covers the query
        if (go_left) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + 1'b1;
        end
        if ((go_left ? lo_r : mid_r + 1'b1) == (go_left ? mid_r : hi_r)) begin
          state_nxt = BK_FETCH;
        end else begin
          state_nxt = BK_STEP;
        end
      end
      BK_FETCH: begin
        rd_addr   = lo_r;
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        ostb_nxt  = 1'b1;
        oid_nxt   = rd_id_r;
        ow_nxt    = rd_w_r;
        ost_nxt   = 1'b0;
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      count_r <= '0;
      run_r   <= '0;
      ready_r <= 1'b0;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      run_r   <= run_nxt;
      ready_r <= ready_nxt;
      ostb_r  <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    x_r   <= x_nxt;
    oid_r <= oid_nxt;
    ow_r  <= ow_nxt;
    ost_r <= ost_nxt;
  end

  // leaf table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr] <= req.leaf_id;
      mem_w[wr_addr]  <= req.leaf_weight;
      mem_p[wr_addr]  <= wr_psum;
    end
    rd_id_r <= mem_id[rd_addr];
    rd_w_r  <= mem_w[rd_addr];
    rd_p_r  <= mem_p[rd_addr];
  end

  assign out_strobe       = ostb_r;
  assign out_found_id     = oid_r;
  assign out_found_weight = ow_r;
  assign out_status       = ost_r;

endmodule

@@ design/weighted_sum_tree_select_core.sv @@
// Top level of the weighted sum tree select core.
// Weighted selection over up to MAX_LEAVES loaded leaves. A load request is
// handled in the idle state of the back end and writes the leaf with its
// running prefix sum, so the request flagged last_leaf leaves the table ready
// with no separate build pass. A search is a binary descent over the prefix
// sums, each level a registered table read (BK_STEP) then a compare (BK_CMP);
// a search on an empty or unfinished table answers with status 1. A two-entry
// queue between the front and the back takes requests while a search runs;
// busy rises once the queue is full and the front register holds one more
// request.
// Each result shows for one cycle on out_strobe and cannot be stalled.
module weighted_sum_tree_select_core
  import wsts_pkg::*;
#(
  parameter int MAX_LEAVES = DEF_MAX_LEAVES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [ID_W-1:0]     in_leaf_id,
  input  logic [WEIGHT_W-1:0] in_leaf_weight,
  input  logic                in_last_leaf,
  input  logic [QUERY_W-1:0]  in_query_value,
  output logic                out_strobe,
  output logic [ID_W-1:0]     out_found_id,
  output logic [WEIGHT_W-1:0] out_found_weight,
  output logic                out_status
);

  q_stat_t  q_stat;
  bk_stat_t bk_stat;
  logic     push;
  req_t     push_req;
  req_t     pop_req;

  wsts_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_leaf_id     (in_leaf_id),
    .in_leaf_weight (in_leaf_weight),
    .in_last_leaf   (in_last_leaf),
    .in_query_value (in_query_value),
    .q_stat         (q_stat),
    .push           (push),
    .push_req       (push_req)
  );

  wsts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (bk_stat.pop),
    .pop_req  (pop_req),
    .stat     (q_stat)
  );

  wsts_back #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .req              (pop_req),
    .stat             (bk_stat),
    .out_strobe       (out_strobe),
    .out_found_id     (out_found_id),
    .out_found_weight (out_found_weight),
    .out_status       (out_status)
  );

  // busy only when the queue is full
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> q_stat.full)
    else $error("busy without a full queue");

  // back end pops only when idle and the queue holds a request
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> (bk_stat.idle && !q_stat.empty))
    else $error("pop outside idle or from an empty queue");

  // empty-table answers carry zero payload
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |-> (out_found_id == '0 && out_found_weight == '0))
    else $error("empty-table result with nonzero payload");

endmodule
